### rtl/core/tqc_pkg.sv
// Shared types and constants for the two-queue cache policy block.
// No dependencies; imported by the top module, tqc_engine and the testbench (not by tqc_slot_ram).
`timescale 1ns / 1ps

package tqc_pkg;

  localparam int DATA_W = 32;
  localparam int CAP_W  = 6;

  typedef enum logic [1:0] {
    L_NONE,
    L_A1IN,
    L_AM,
    L_A1OUT
  } list_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH,
    ST_PASS,
    ST_TAIL,
    ST_WR,
    ST_NEXT,
    ST_DONE
  } state_t;

  typedef enum logic [3:0] {
    PH_SRCH,
    PH_MTF,
    PH_FIN,
    PH_PROMO_UNL,
    PH_PROMO_PUSH,
    PH_CHK_AM,
    PH_EV_TAIL,
    PH_EV_UNL,
    PH_INS_WR,
    PH_INS_PUSH,
    PH_CHK_IN,
    PH_DM_TAIL,
    PH_DM_UNL,
    PH_DM_PUSH,
    PH_CHK_OUT
  } phase_t;

  typedef enum logic [1:0] {
    PM_INC,
    PM_LT,
    PM_GT
  } pmode_t;

  typedef struct packed {
    logic              op;
    logic [DATA_W-1:0] key;
    logic [DATA_W-1:0] val;
  } cmd_t;

  typedef struct packed {
    logic              hit;
    logic              value_valid;
    logic [DATA_W-1:0] read_value;
    logic [DATA_W-1:0] hit_count;
    logic [DATA_W-1:0] access_count;
  } res_t;

endpackage

### rtl/core/two_queue_cache_policy.sv
// Timing: a get miss needs one search walk of the slot store; a get hit adds one renumber
// walk; the longest command is a put miss with demotion and eviction. Every walk goes
// through the single read port of the slot store, one slot per cycle.
// Throughput: one word at a time; the next word is taken while a result waits.
// Reset: synchronous, active low; list tags and counters clear at once, capacity is 32.
`timescale 1ns / 1ps

module two_queue_cache_policy #(
  parameter int MAX_CAPACITY = 32,
  parameter int SLOTS        = 64
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [tqc_pkg::CAP_W-1:0] cfg_data,   // total_capacity
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,   // key[31:0], write_value[63:32]
  input  logic [0:0]                in_tuser,   // operation
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [103:0]              out_tdata,  // hit, read_value, hit_count, access_count
  output logic [0:0]                out_tuser   // value_valid
);
  import tqc_pkg::*;

  logic [CAP_W-1:0] cap_r;
  logic             out_tvalid_r;
  logic [103:0]     out_tdata_r;
  logic             out_tuser_r;
  logic             eng_idle, eng_done, out_free, start;
  cmd_t             cmd;
  res_t             res;

  assign cfg_ready = 1'b1;
  assign in_tready = eng_idle;
  assign start     = in_tvalid && in_tready;
  assign cmd.op    = in_tuser[0];
  assign cmd.key   = in_tdata[31:0];
  assign cmd.val   = in_tdata[63:32];
  assign out_free  = !out_tvalid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(32);
    end else if (cfg_valid) begin
      cap_r <= cfg_data;
    end
  end

  tqc_engine #(.SLOTS(SLOTS), .MAX_CAPACITY(MAX_CAPACITY)) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .cmd     (cmd),
    .cap     (cap_r),
    .out_free(out_free),
    .idle    (eng_idle),
    .done    (eng_done),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (eng_done) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_done) begin
      out_tdata_r <= {7'd0, res.access_count, res.hit_count, res.read_value, res.hit};
      out_tuser_r <= res.value_valid;
    end
  end

  assign out_tvalid   = out_tvalid_r;
  assign out_tdata    = out_tdata_r;
  assign out_tuser[0] = out_tuser_r;

endmodule

### rtl/core/tqc_slot_ram.sv
// Slot store: one write port, one registered read port.
// Holds key, value and rank of every slot. No dependencies.
`timescale 1ns / 1ps

module tqc_slot_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 70
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/tqc_engine.sv
// List sequencer: walks the slot store for search, rank renumbering and tail lookup.
// Depends on tqc_pkg and tqc_slot_ram.
`timescale 1ns / 1ps

module tqc_engine #(
  parameter int SLOTS        = 64,
  parameter int MAX_CAPACITY = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  tqc_pkg::cmd_t              cmd,
  input  logic [tqc_pkg::CAP_W-1:0]  cap,
  input  logic                       out_free,
  output logic                       idle,
  output logic                       done,
  output tqc_pkg::res_t              res
);
  import tqc_pkg::*;

  localparam int IW   = $clog2(SLOTS);
  localparam int RKW  = IW;
  localparam int CNTW = $clog2(SLOTS + 1);
  localparam int CMPW = (CNTW > 7) ? CNTW : 7;
  localparam int WW   = 2 * DATA_W + RKW;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  list_t  pass_list_r, pass_list_nxt;
  pmode_t pass_mode_r, pass_mode_nxt;
  logic [RKW-1:0] pass_rank_r, pass_rank_nxt;
  logic [RKW-1:0] wr_rank_r, wr_rank_nxt;

  list_t lst_r [SLOTS];
  list_t lst_rd_r;
  logic [CNTW-1:0] cnt_r [3];

  logic              op_r;
  logic [DATA_W-1:0] key_r, val_r;
  logic              fnd_r, free_fnd_r, tail_fnd_r;
  logic [IW-1:0]     fidx_r, free_idx_r, tgt_idx_r;
  logic [DATA_W-1:0] fval_r, tgt_key_r, tgt_val_r;
  logic [RKW-1:0]    frank_r, tail_rank_r;
  list_t             flist_r;
  logic [DATA_W-1:0] hits_r, gets_r;
  res_t              res_r;

  logic          iss_r, pv_r;
  logic [IW-1:0] rd_idx_r, pidx_r;
  logic          wlk, wlk_nxt, wk_start, wk_end;

  logic [WW-1:0]     rdata, wdata;
  logic              mem_we;
  logic [IW-1:0]     waddr;
  logic [DATA_W-1:0] d_key, d_val;
  logic [RKW-1:0]    d_rank, p_rank;
  list_t             d_lst;
  logic              p_we;

  logic          ls_we, c_inc, c_dec;
  list_t         ls_val, c_list;
  logic [CAP_W-1:0] eff_cap, am_cap;
  logic [CAP_W-3:0] a1in_cap;
  logic [CAP_W-2:0] a1out_cap;
  logic          am_over, in_over, out_over, f_hit, op_get;
  logic [DATA_W-1:0] hits_inc, gets_inc;

  function automatic logic [1:0] cix(list_t l);
    return 2'(l) - 2'd1;
  endfunction

  // list limits
  assign eff_cap   = (32'(cap) > 32'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : cap;
  assign a1in_cap  = eff_cap[CAP_W-1:2];
  assign am_cap    = eff_cap - CAP_W'(a1in_cap);
  assign a1out_cap = {a1in_cap, 1'b0};
  assign am_over   = CMPW'(cnt_r[cix(L_AM)]) > CMPW'(am_cap);
  assign in_over   = CMPW'(cnt_r[cix(L_A1IN)]) > CMPW'(a1in_cap);
  assign out_over  = CMPW'(cnt_r[cix(L_A1OUT)]) > CMPW'(a1out_cap);

  assign op_get = !op_r;
  assign f_hit  = fnd_r && (flist_r == L_A1IN || flist_r == L_AM);
  assign hits_inc = (hits_r != '1) ? hits_r + DATA_W'(1) : hits_r;
  assign gets_inc = (gets_r != '1) ? gets_r + DATA_W'(1) : gets_r;

  // walker
  assign wlk     = (state_r == ST_SRCH) || (state_r == ST_PASS) || (state_r == ST_TAIL);
  assign wlk_nxt = (state_nxt == ST_SRCH) || (state_nxt == ST_PASS) || (state_nxt == ST_TAIL);
  assign wk_start = wlk_nxt && !wlk;
  assign wk_end   = pv_r && (pidx_r == IW'(SLOTS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r    <= 1'b0;
      pv_r     <= 1'b0;
      rd_idx_r <= '0;
      pidx_r   <= '0;
      lst_rd_r <= L_NONE;
    end else begin
      pv_r   <= iss_r;
      pidx_r <= rd_idx_r;
      if (iss_r) lst_rd_r <= lst_r[rd_idx_r];
      if (wk_start) begin
        iss_r    <= 1'b1;
        rd_idx_r <= '0;
      end else if (iss_r) begin
        rd_idx_r <= rd_idx_r + IW'(1);
        if (rd_idx_r == IW'(SLOTS - 1)) begin
          iss_r <= 1'b0;
        end
      end
    end
  end

  assign d_rank = rdata[RKW-1:0];
  assign d_val  = rdata[RKW +: DATA_W];
  assign d_key  = rdata[RKW+DATA_W +: DATA_W];
  assign d_lst  = lst_rd_r;

  always_comb begin
    p_we   = 1'b0;
    p_rank = d_rank + RKW'(1);
    if (state_r == ST_PASS && pv_r && d_lst == pass_list_r) begin
      case (pass_mode_r)
        PM_INC: p_we = 1'b1;
        PM_LT:  p_we = d_rank < pass_rank_r;
        PM_GT: begin
          p_we   = d_rank > pass_rank_r;
          p_rank = d_rank - RKW'(1);
        end
        default: p_we = 1'b0;
      endcase
    end
  end

  always_comb begin
    if (state_r == ST_WR) begin
      mem_we = 1'b1;
      waddr  = tgt_idx_r;
      wdata  = {tgt_key_r, tgt_val_r, wr_rank_r};
    end else begin
      mem_we = p_we;
      waddr  = pidx_r;
      wdata  = {d_key, d_val, p_rank};
    end
  end

  tqc_slot_ram #(.DEPTH(SLOTS), .WIDTH(WW)) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (iss_r),
    .raddr(rd_idx_r),
    .rdata(rdata)
  );

  // next state
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    pass_list_nxt = pass_list_r;
    pass_mode_nxt = pass_mode_r;
    pass_rank_nxt = pass_rank_r;
    wr_rank_nxt   = wr_rank_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_SRCH;
          phase_nxt = PH_SRCH;
        end
      end
      ST_SRCH, ST_PASS, ST_TAIL: begin
        if (wk_end) state_nxt = ST_NEXT;
      end
      ST_WR:   state_nxt = ST_NEXT;
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      ST_NEXT: begin
        state_nxt = ST_DONE;
        case (phase_r)
          PH_SRCH: begin
            if (op_get) begin
              if (f_hit) begin
                state_nxt = ST_PASS; pass_list_nxt = flist_r;
                pass_mode_nxt = PM_LT; pass_rank_nxt = frank_r; phase_nxt = PH_MTF;
              end
            end else if (fnd_r) begin
              case (flist_r)
                L_A1IN: begin
                  state_nxt = ST_WR; wr_rank_nxt = frank_r; phase_nxt = PH_FIN;
                end
                L_AM: begin
                  state_nxt = ST_PASS; pass_list_nxt = L_AM;
                  pass_mode_nxt = PM_LT; pass_rank_nxt = frank_r; phase_nxt = PH_MTF;
                end
                default: begin
                  state_nxt = ST_PASS; pass_list_nxt = L_A1OUT;
                  pass_mode_nxt = PM_GT; pass_rank_nxt = frank_r; phase_nxt = PH_PROMO_UNL;
                end
              endcase
            end else if (free_fnd_r) begin
              state_nxt = ST_WR; wr_rank_nxt = '0; phase_nxt = PH_INS_WR;
            end
          end
          PH_MTF, PH_PROMO_PUSH, PH_DM_PUSH: begin
            state_nxt   = ST_WR;
            wr_rank_nxt = '0;
            phase_nxt   = (phase_r == PH_MTF) ? PH_FIN :
                          (phase_r == PH_PROMO_PUSH) ? PH_CHK_AM : PH_CHK_OUT;
          end
          PH_PROMO_UNL: begin
            state_nxt = ST_PASS; pass_list_nxt = L_AM;
            pass_mode_nxt = PM_INC; phase_nxt = PH_PROMO_PUSH;
          end
          PH_CHK_AM: begin
            if (am_over) begin
              state_nxt = ST_TAIL; pass_list_nxt = L_AM; phase_nxt = PH_EV_TAIL;
            end
          end
          PH_EV_TAIL: begin
            if (tail_fnd_r) begin
              state_nxt = ST_PASS; pass_mode_nxt = PM_GT;
              pass_rank_nxt = tail_rank_r; phase_nxt = PH_EV_UNL;
            end
          end
          PH_INS_WR: begin
            state_nxt = ST_PASS; pass_list_nxt = L_A1IN;
            pass_mode_nxt = PM_INC; phase_nxt = PH_INS_PUSH;
          end
          PH_INS_PUSH: begin
            state_nxt = ST_NEXT; phase_nxt = PH_CHK_IN;
          end
          PH_CHK_IN: begin
            if (in_over) begin
              state_nxt = ST_TAIL; pass_list_nxt = L_A1IN; phase_nxt = PH_DM_TAIL;
            end
          end
          PH_DM_TAIL: begin
            if (tail_fnd_r) begin
              state_nxt = ST_PASS; pass_list_nxt = L_A1IN; pass_mode_nxt = PM_GT;
              pass_rank_nxt = tail_rank_r; phase_nxt = PH_DM_UNL;
            end
          end
          PH_DM_UNL: begin
            state_nxt = ST_PASS; pass_list_nxt = L_A1OUT;
            pass_mode_nxt = PM_INC; phase_nxt = PH_DM_PUSH;
          end
          PH_CHK_OUT: begin
            if (out_over) begin
              state_nxt = ST_TAIL; pass_list_nxt = L_A1OUT; phase_nxt = PH_EV_TAIL;
            end
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    ls_we  = 1'b0;
    ls_val = L_NONE;
    c_inc  = 1'b0;
    c_dec  = 1'b0;
    c_list = pass_list_r;
    idle   = (state_r == ST_IDLE);
    done   = (state_r == ST_DONE) && out_free;
    if (state_r == ST_NEXT) begin
      case (phase_r)
        PH_PROMO_UNL: begin ls_we = 1'b1; c_dec = 1'b1; c_list = L_A1OUT; end
        PH_PROMO_PUSH: begin ls_we = 1'b1; ls_val = L_AM; c_inc = 1'b1; c_list = L_AM; end
        PH_EV_UNL: begin ls_we = 1'b1; c_dec = 1'b1; end
        PH_INS_PUSH: begin ls_we = 1'b1; ls_val = L_A1IN; c_inc = 1'b1; c_list = L_A1IN; end
        PH_DM_UNL: begin ls_we = 1'b1; c_dec = 1'b1; c_list = L_A1IN; end
        PH_DM_PUSH: begin ls_we = 1'b1; ls_val = L_A1OUT; c_inc = 1'b1; c_list = L_A1OUT; end
        default: ls_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_SRCH;
      pass_list_r <= L_NONE;
      pass_mode_r <= PM_INC;
      pass_rank_r <= '0;
      wr_rank_r   <= '0;
      hits_r      <= '0;
      gets_r      <= '0;
      fnd_r       <= 1'b0;
      free_fnd_r  <= 1'b0;
      tail_fnd_r  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) lst_r[i] <= L_NONE;
      for (int j = 0; j < 3; j++) cnt_r[j] <= '0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pass_list_r <= pass_list_nxt;
      pass_mode_r <= pass_mode_nxt;
      pass_rank_r <= pass_rank_nxt;
      wr_rank_r   <= wr_rank_nxt;
      if (ls_we) lst_r[tgt_idx_r] <= ls_val;
      if (c_inc) begin
        cnt_r[cix(c_list)] <= cnt_r[cix(c_list)] + CNTW'(1);
      end else if (c_dec && cnt_r[cix(c_list)] != '0) begin
        cnt_r[cix(c_list)] <= cnt_r[cix(c_list)] - CNTW'(1);
      end
      if (wk_start && state_nxt == ST_SRCH) begin
        fnd_r      <= 1'b0;
        free_fnd_r <= 1'b0;
      end else if (state_r == ST_SRCH && pv_r) begin
        if (!fnd_r && d_lst != L_NONE && d_key == key_r) begin
          fnd_r   <= 1'b1;
          fidx_r  <= pidx_r;
          fval_r  <= d_val;
          frank_r <= d_rank;
          flist_r <= d_lst;
        end
        if (!free_fnd_r && d_lst == L_NONE) begin
          free_fnd_r <= 1'b1;
          free_idx_r <= pidx_r;
        end
      end
      if (wk_start && state_nxt == ST_TAIL) begin
        tail_fnd_r <= 1'b0;
      end else if (state_r == ST_TAIL && pv_r && !tail_fnd_r && d_lst == pass_list_r &&
                   CNTW'(d_rank) + CNTW'(1) == cnt_r[cix(pass_list_r)]) begin
        tail_fnd_r  <= 1'b1;
        tail_rank_r <= d_rank;
        tgt_idx_r   <= pidx_r;
        tgt_key_r   <= d_key;
        tgt_val_r   <= d_val;
      end
      if (state_r == ST_NEXT && phase_r == PH_SRCH) begin
        tgt_idx_r <= fnd_r ? fidx_r : free_idx_r;
        tgt_key_r <= key_r;
        tgt_val_r <= op_r ? val_r : fval_r;
        if (op_get) begin
          gets_r <= gets_inc;
          if (f_hit) hits_r <= hits_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && state_r == ST_IDLE) begin
      op_r  <= cmd.op;
      key_r <= cmd.key;
      val_r <= cmd.val;
    end
    if (state_r == ST_NEXT && phase_r == PH_SRCH) begin
      res_r.hit          <= op_get && f_hit;
      res_r.value_valid  <= op_get && fnd_r;
      res_r.read_value   <= (op_get && fnd_r) ? fval_r : '0;
      res_r.hit_count    <= (op_get && f_hit) ? hits_inc : hits_r;
      res_r.access_count <= op_get ? gets_inc : gets_r;
    end
  end

  assign res = res_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == ST_IDLE)
    else $error("command taken while busy");

  a_rmw_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_we && iss_r) |-> waddr != rd_idx_r)
    else $error("slot write collides with walker read");

  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cnt_r[0]) + int'(cnt_r[1]) + int'(cnt_r[2])) <= SLOTS)
    else $error("list counts exceed slot count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle");

  a_walk_end: assert property (@(posedge clk) disable iff (!rst_n)
    (wlk && wk_end) |=> (state_r == ST_NEXT && !iss_r))
    else $error("walk ended without dispatch");

endmodule

### test/tb_two_queue_cache_policy.sv
// Self-checking testbench for two_queue_cache_policy: random and directed get/put words
// are checked against a 2Q list predictor kept in the bench. Uses tqc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_two_queue_cache_policy;
  import tqc_pkg::*;

  localparam int NSLOT = 64;
  localparam int MAXCAP = 32;
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [5:0]   cfg_data = '0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [63:0]  in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [103:0] out_tdata;
  logic [0:0]   out_tuser;

  two_queue_cache_policy u_top (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  // cache shadow
  list_t       sh_list [NSLOT];
  logic [31:0] sh_key  [NSLOT];
  logic [31:0] sh_val  [NSLOT];
  int          sh_rank [NSLOT];
  int          sh_cnt  [4];
  logic [31:0] sh_hits, sh_gets;
  int          sh_cap;

  res_t expected_q [$];
  int   n_err = 0, n_words = 0, n_results = 0, n_hits_seen = 0;
  bit   calm = 0;
  int   hold_req = 0;

  initial forever #6 clk = ~clk;

  initial begin
    #(12.0 * 1500000);
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------- predictor ----------------
  function automatic int eff_cap();
    return (sh_cap > MAXCAP) ? MAXCAP : sh_cap;
  endfunction

  function automatic void unlink(int s);
    list_t l;
    int r;
    l = sh_list[s];
    r = sh_rank[s];
    if (l == L_NONE) return;
    for (int i = 0; i < NSLOT; i++)
      if (sh_list[i] == l && sh_rank[i] > r) sh_rank[i]--;
    if (sh_cnt[l] > 0) sh_cnt[l]--;
    sh_list[s] = L_NONE;
  endfunction

  function automatic void push_head(int s, list_t l);
    for (int i = 0; i < NSLOT; i++)
      if (sh_list[i] == l) sh_rank[i]++;
    sh_list[s] = l;
    sh_rank[s] = 0;
    sh_cnt[l]++;
  endfunction

  function automatic void to_front(int s);
    int r;
    r = sh_rank[s];
    for (int i = 0; i < NSLOT; i++)
      if (sh_list[i] == sh_list[s] && sh_rank[i] < r) sh_rank[i]++;
    sh_rank[s] = 0;
  endfunction

  function automatic int tail_of(list_t l);
    if (sh_cnt[l] == 0) return -1;
    for (int i = 0; i < NSLOT; i++)
      if (sh_list[i] == l && sh_rank[i] == sh_cnt[l] - 1) return i;
    return -1;
  endfunction

  function automatic void drop_tail(list_t l);
    int t;
    t = tail_of(l);
    if (t >= 0) unlink(t);
  endfunction

  function automatic res_t cache_access(logic op, logic [31:0] key, logic [31:0] val);
    res_t r;
    int s, t, fr, in_cap;
    r = '0;
    s = -1;
    for (int i = 0; i < NSLOT; i++)
      if (s < 0 && sh_list[i] != L_NONE && sh_key[i] == key) s = i;
    if (op == OP_PUT) begin
      if (s >= 0) begin
        sh_val[s] = val;
        if (sh_list[s] == L_AM) to_front(s);
        else if (sh_list[s] == L_A1OUT) begin
          unlink(s);
          push_head(s, L_AM);
          if (sh_cnt[L_AM] > eff_cap() - eff_cap() / 4) drop_tail(L_AM);
        end
      end else begin
        in_cap = eff_cap() / 4;
        fr = -1;
        for (int i = 0; i < NSLOT; i++)
          if (fr < 0 && sh_list[i] == L_NONE) fr = i;
        if (fr >= 0) begin
          sh_key[fr] = key;
          sh_val[fr] = val;
          push_head(fr, L_A1IN);
          if (sh_cnt[L_A1IN] > in_cap) begin
            t = tail_of(L_A1IN);
            if (t >= 0) begin
              unlink(t);
              push_head(t, L_A1OUT);
              if (sh_cnt[L_A1OUT] > 2 * in_cap) drop_tail(L_A1OUT);
            end
          end
        end
      end
    end else begin
      if (sh_gets != 32'hFFFF_FFFF) sh_gets++;
      if (s >= 0) begin
        r.value_valid = 1'b1;
        r.read_value = sh_val[s];
        if (sh_list[s] == L_A1IN || sh_list[s] == L_AM) begin
          to_front(s);
          r.hit = 1'b1;
          if (sh_hits != 32'hFFFF_FFFF) sh_hits++;
        end
      end
    end
    r.hit_count = sh_hits;
    r.access_count = sh_gets;
    return r;
  endfunction

  // ---------------- drivers ----------------
  task automatic send_word(logic op, logic [31:0] key, logic [31:0] val);
    if (!calm && $urandom_range(99) < 24) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {val, key};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_q.push_back(cache_access(op, key, val));
    n_words++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(int c);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= c[5:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sh_cap = c;
  endtask

  // receiver: random stalls, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_tready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      out_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end
  end

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h (result %0d)", what, got, want, n_results);
    n_err++;
  endtask

  always @(posedge clk) begin
    res_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        $display("unexpected result word %0d", n_results);
        n_err++;
      end else begin
        w = expected_q.pop_front();
        if (out_tdata[0] !== w.hit)
          report_mismatch("hit", 32'(out_tdata[0]), 32'(w.hit));
        if (out_tuser[0] !== w.value_valid)
          report_mismatch("value_valid", 32'(out_tuser[0]), 32'(w.value_valid));
        if (out_tdata[32:1] !== w.read_value)
          report_mismatch("read_value", out_tdata[32:1], w.read_value);
        if (out_tdata[64:33] !== w.hit_count)
          report_mismatch("hit_count", out_tdata[64:33], w.hit_count);
        if (out_tdata[96:65] !== w.access_count)
          report_mismatch("access_count", out_tdata[96:65], w.access_count);
        if (w.hit) n_hits_seen++;
      end
      n_results++;
    end
  end

  // ---------------- tests ----------------
  task automatic test_directed();
    send_word(OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
    send_word(OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    send_word(OP_GET, 32'h8000_0000, 32'h0);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_PUT, 32'h8000_0000, 32'hFFFF_FFFF);
    send_word(OP_GET, 32'h8000_0000, 32'h0);
    // push 10 new keys through A1in so early ones land in A1out
    for (int k = 1; k <= 10; k++) send_word(OP_PUT, k, 32'h100 + k);
    send_word(OP_GET, 32'h8000_0000, 32'h0);
    send_word(OP_PUT, 32'h7FFF_FFFF, 32'h1234_5678);
    send_word(OP_GET, 32'h7FFF_FFFF, 32'h0);
    send_word(OP_GET, 32'h5555_AAAA, 32'h0);
  endtask

  task automatic test_capacity_extremes();
    int caps[6] = '{63, 0, 1, 4, 5, 33};
    foreach (caps[i]) begin
      write_capacity(caps[i]);
      for (int k = 0; k < 12; k++)
        send_word($urandom_range(1) ? OP_PUT : OP_GET, $urandom_range(20), $urandom);
    end
    write_capacity(32);
  endtask

  task automatic test_output_backpressure();
    hold_req = 600;
    for (int k = 0; k < 6; k++) send_word(OP_PUT, 200 + k, $urandom);
    for (int k = 0; k < 6; k++) send_word(OP_GET, 200 + k, 32'h0);
  endtask

  task automatic test_random(int n);
    logic [31:0] key;
    int cnt;
    cnt = 0;
    while (cnt < n) begin
      calm = (cnt >= 150 && cnt < 230);
      if (cnt % 120 == 60) begin
        write_capacity($urandom_range(63));
        calm = (cnt >= 150 && cnt < 230);
      end
      if ($urandom_range(9) < 8) begin
        // put a small burst of keys, each followed by a get of that key or of a random one
        for (int j = 0; j < 3; j++) begin
          key = $urandom_range(47);
          send_word(OP_PUT, key, $urandom);
          send_word(OP_GET, $urandom_range(1) ? key : $urandom_range(47), $urandom);
          cnt += 2;
        end
      end else begin
        key = $urandom;
        send_word($urandom_range(1) ? OP_PUT : OP_GET, key, $urandom);
        send_word(OP_GET, key, $urandom);
        cnt += 2;
      end
    end
    calm = 0;
  endtask

  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      sh_list[i] = L_NONE;
      sh_key[i] = '0;
      sh_val[i] = '0;
      sh_rank[i] = 0;
    end
    sh_cnt = '{0, 0, 0, 0};
    sh_hits = '0;
    sh_gets = '0;
    sh_cap = 32;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_capacity_extremes();
    test_output_backpressure();
    test_random(450);
    write_capacity(63);
    test_random(20);
    wait_drained();
    repeat (500) @(posedge clk);
    $display("Covered %0d words (%0d get hits) over capacities 0..63 with stalls.",
             n_words, n_hits_seen);
    if (n_err == 0 && expected_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
